>>> rtl/core/rrs_pkg.sv
// Shared types and constants for the rounded-rectangle pixel shader.
// No dependencies; used by the shader top level and its checker.
`timescale 1ns / 1ps

package rrs_pkg;

  // Screen geometry (16..4096 each)
  localparam int FB_COLS = 1024;
  localparam int FB_ROWS = 768;

  localparam int SCR_W   = 13;   // holds any screen dimension up to 4096
  localparam int ADDR_W  = 20;
  localparam int PROD_W  = 24;   // 11-bit row times 13-bit width

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA   = 4'd7;

  localparam logic [3:0]  RADIUS_RESET = 4'd8;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  ALPHA_TOP    = 8'hFF;

  typedef struct packed {
    logic [9:0]  col_offset;
    logic [9:0]  row_offset;
    logic [31:0] background_pixel;
  } pix_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [31:0]       pixel_value;
  } res_t;

endpackage

>>> rtl/core/rounded_rect_alpha_pixel_shader_top.sv
// Rounded-rectangle coverage test, screen clip and alpha blend, three stages.
// Depends on rrs_pkg for the item structs, screen size and register indexes.
`timescale 1ns / 1ps

// Each accepted item passes the stage 1, 2 and 3 registers before its result is on res_valid.
// Throughput: one item per clock while res_stall is low; all three stages advance
// independently, so bubbles close up behind a stalled result.
// Reset (rst, synchronous): clears the stage valid bits and loads the
// registers with their defaults (radius 8, alpha 255, all else 0).
module rounded_rect_alpha_pixel_shader_top (
  input  logic                           clk,
  input  logic                           rst,
  // pixel item channel
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  rrs_pkg::pix_t                  pix_data,
  // result channel
  output logic                           res_valid,
  input  logic                           res_stall,
  output rrs_pkg::res_t                  res_data,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic               draw_mode;
  logic [3:0]         corner_radius;
  logic [10:0]        rect_width;
  logic [10:0]        rect_height;
  logic signed [10:0] origin_x;
  logic signed [10:0] origin_y;
  logic [31:0]        draw_color;
  logic [7:0]         blend_alpha;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode     <= 1'b0;
      corner_radius <= rrs_pkg::RADIUS_RESET;
      rect_width    <= '0;
      rect_height   <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
      draw_color    <= '0;
      blend_alpha   <= rrs_pkg::ALPHA_OPAQUE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rrs_pkg::CFG_DRAW_MODE:     draw_mode     <= cfg_data[0];
        rrs_pkg::CFG_CORNER_RADIUS: corner_radius <= cfg_data[3:0];
        rrs_pkg::CFG_RECT_WIDTH:    rect_width    <= cfg_data[10:0];
        rrs_pkg::CFG_RECT_HEIGHT:   rect_height   <= cfg_data[10:0];
        rrs_pkg::CFG_ORIGIN_X:      origin_x      <= $signed(cfg_data[10:0]);
        rrs_pkg::CFG_ORIGIN_Y:      origin_y      <= $signed(cfg_data[10:0]);
        rrs_pkg::CFG_DRAW_COLOR:    draw_color    <= cfg_data;
        rrs_pkg::CFG_BLEND_ALPHA:   blend_alpha   <= cfg_data[7:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor
  // loads. Stall reaches the input only when every stage holds an item.
  // ---------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic en1, en2, en3;

  assign en3       = !s3_valid || !res_stall;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign pix_stall = !en1;

  // ---------------------------------------------------------------
  // Stage 1 logic: effective radius, corner and edge classification,
  // screen position and clip.
  // ---------------------------------------------------------------
  logic [9:0]         col, row;
  logic [3:0]         rad;
  logic [10:0]        w_minus_r, h_minus_r;
  logic [10:0]        dx_right, dy_bottom;
  logic               in_rect, left, right, top, bottom;
  logic               on_hline, on_vline;
  logic signed [11:0] scr_x, scr_y;
  logic               on_screen;
  logic [3:0]         dx, dy;

  assign col = pix_data.col_offset;
  assign row = pix_data.row_offset;

  always_comb begin
    rad = corner_radius;
    // clamp to half width, then half height; a clamped value is below 16
    if ({7'b0, rad} > {1'b0, rect_width[10:1]})  rad = rect_width[4:1];
    if ({7'b0, rad} > {1'b0, rect_height[10:1]}) rad = rect_height[4:1];
  end

  assign w_minus_r = rect_width  - {7'b0, rad};
  assign h_minus_r = rect_height - {7'b0, rad};

  assign in_rect = ({1'b0, col} < rect_width) && ({1'b0, row} < rect_height);
  assign left    = {1'b0, col} < {7'b0, rad};
  assign right   = {1'b0, col} >= w_minus_r;
  assign top     = {1'b0, row} < {7'b0, rad};
  assign bottom  = {1'b0, row} >= h_minus_r;

  // distances from the inner corner cell; only meaningful inside a corner
  assign dx_right  = {1'b0, col} - w_minus_r;
  assign dy_bottom = {1'b0, row} - h_minus_r;
  assign dx = left ? (rad - col[3:0] - 4'd1) : dx_right[3:0];
  assign dy = top  ? (rad - row[3:0] - 4'd1) : dy_bottom[3:0];

  // straight border lines, corner squares excluded
  assign on_hline = ((row == 10'd0) || ({1'b0, row} == rect_height - 11'd1))
                    && !left && !right;
  assign on_vline = ((col == 10'd0) || ({1'b0, col} == rect_width - 11'd1))
                    && !top && !bottom;

  assign scr_x = {origin_x[10], origin_x} + $signed({2'b00, col});
  assign scr_y = {origin_y[10], origin_y} + $signed({2'b00, row});
  assign on_screen = !scr_x[11] && !scr_y[11]
                  && ({{(rrs_pkg::SCR_W-11){1'b0}}, scr_x[10:0]}
                      < rrs_pkg::SCR_W'(rrs_pkg::FB_COLS))
                  && ({{(rrs_pkg::SCR_W-11){1'b0}}, scr_y[10:0]}
                      < rrs_pkg::SCR_W'(rrs_pkg::FB_ROWS));

  logic [3:0]  s1_rad, s1_dx, s1_dy;
  logic        s1_corner, s1_edge, s1_keep;
  logic [10:0] s1_sx, s1_sy;
  logic [31:0] s1_bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_rad    <= rad;
      s1_dx     <= dx;
      s1_dy     <= dy;
      s1_corner <= (left || right) && (top || bottom);
      s1_edge   <= on_hline || on_vline;
      // in rectangle, on screen and not fully transparent
      s1_keep   <= in_rect && on_screen && (blend_alpha != 8'd0);
      s1_sx     <= scr_x[10:0];
      s1_sy     <= scr_y[10:0];
      s1_bg     <= pix_data.background_pixel;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: squared distances, row base address, channel products.
  // ---------------------------------------------------------------
  logic [8:0]  d2;
  logic [3:0]  rad_m1;
  logic [rrs_pkg::PROD_W-1:0] row_base;
  logic [7:0]  alpha_inv;

  assign d2        = 9'({5'b0, s1_dx} * {5'b0, s1_dx}) + 9'({5'b0, s1_dy} * {5'b0, s1_dy});
  assign rad_m1    = s1_rad - 4'd1;  // r = 0 never reaches a corner
  assign row_base  = {{(rrs_pkg::PROD_W-11){1'b0}}, s1_sy}
                   * rrs_pkg::PROD_W'(rrs_pkg::FB_COLS);
  assign alpha_inv = rrs_pkg::ALPHA_OPAQUE - blend_alpha;

  logic [8:0]  s2_d2;
  logic [7:0]  s2_rr, s2_rr_in;
  logic        s2_corner, s2_edge, s2_keep;
  logic [rrs_pkg::ADDR_W-1:0] s2_base;
  logic [10:0] s2_sx;
  logic [15:0] s2_mix [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d2     <= d2;
      s2_rr     <= 8'({4'b0, s1_rad} * {4'b0, s1_rad});
      s2_rr_in  <= 8'({4'b0, rad_m1} * {4'b0, rad_m1});
      s2_corner <= s1_corner;
      s2_edge   <= s1_edge;
      s2_keep   <= s1_keep;
      s2_base   <= row_base[rrs_pkg::ADDR_W-1:0];
      s2_sx     <= s1_sx;
      // c*a + b*(255-a), at most 255*255
      for (int k = 0; k < 3; k++) begin
        s2_mix[k] <= 16'({8'b0, draw_color[8*k +: 8]} * {8'b0, blend_alpha})
                   + 16'({8'b0, s1_bg[8*k +: 8]} * {8'b0, alpha_inv});
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 3 logic: final coverage, address, divide by 255, output mux.
  // ---------------------------------------------------------------
  logic        in_disc, in_ring, covered, we;
  logic [16:0] quot [3];
  logic [31:0] blended;

  assign in_disc = {1'b0, s2_d2} <= {2'b0, s2_rr};
  assign in_ring = in_disc && ({1'b0, s2_d2} >= {2'b0, s2_rr_in});

  always_comb begin
    if (s2_corner) begin
      covered = draw_mode ? in_ring : in_disc;
    end else begin
      covered = draw_mode ? s2_edge : 1'b1;
    end
  end

  assign we = covered && s2_keep;

  // x/255 == (x + (x>>8) + 1) >> 8 for every x up to 255*255
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot[k] = {1'b0, s2_mix[k]} + {9'b0, s2_mix[k][15:8]} + 17'd1;
    end
    blended = {rrs_pkg::ALPHA_TOP, quot[2][15:8], quot[1][15:8], quot[0][15:8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res_data.write_enable <= we;
      res_data.pixel_address <= we ? (s2_base + {{(rrs_pkg::ADDR_W-11){1'b0}}, s2_sx})
                                   : '0;
      if (!we) begin
        res_data.pixel_value <= '0;
      end else if (blend_alpha == rrs_pkg::ALPHA_OPAQUE) begin
        res_data.pixel_value <= draw_color;
      end else begin
        res_data.pixel_value <= blended;
      end
    end
  end

  assign res_valid = s3_valid;

endmodule

>>> rtl/core/rrs_checker.sv
// Port-level checks for the rounded-rectangle pixel shader, bound to its top.
// Depends on rrs_pkg for the result struct and screen size.
`timescale 1ns / 1ps

module rrs_checker (
  input logic          clk,
  input logic          rst,
  input logic          pix_stall,
  input logic          res_valid,
  input logic          res_stall,
  input rrs_pkg::res_t res_data
);

  localparam longint SCREEN_SPAN =
    longint'(rrs_pkg::FB_COLS) * longint'(rrs_pkg::FB_ROWS);
  localparam bit SPAN_FITS = SCREEN_SPAN <= (longint'(1) << rrs_pkg::ADDR_W);

  // a held result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // an empty output slot never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !pix_stall)
    else $error("input stalled with an empty output stage");

  // a skipped pixel carries zero address and value
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.write_enable |->
      res_data.pixel_address == '0 && res_data.pixel_value == '0)
    else $error("skipped pixel has nonzero fields");

  // a written pixel lands inside the framebuffer
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.write_enable && SPAN_FITS |->
      longint'(res_data.pixel_address) < SCREEN_SPAN)
    else $error("pixel address beyond the screen");

endmodule

bind rounded_rect_alpha_pixel_shader_top rrs_checker u_rrs_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);
